// ===== design/spa_pkg.sv =====
// shared types, codes and constants for the slot pool allocator
// no dependencies; imported by every module of the block
package spa_pkg;

    localparam int unsigned POOL_SLOTS_DEF = 1024;
    localparam int unsigned ALIGN_BYTES    = 64;
    localparam int unsigned SIZE_MAX_BYTES = 4096;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned GIVEN_W  = 10;
    localparam int unsigned OFFSET_W = 22;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned ESIZE_W  = 13;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GET   = 2'd2,
        CMD_CHECK = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EXHAUSTED = 2'd1,
        STS_RANGE     = 2'd2,
        STS_NOT_OCC   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEM_SIZE = 1'd0,
        CFG_ALIGN     = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_READ,
        BK_EXEC
    } t_bstate;

    // classified command as it travels through the queue
    typedef struct packed {
        t_cmd             cmd;
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        t_status             status;
        logic [GIVEN_W-1:0]  given_index;
        logic [OFFSET_W-1:0] slot_offset;
        logic                is_occupied;
        logic [COUNT_W-1:0]  live_slots;
        logic [COUNT_W-1:0]  peak_slots;
        logic [TOTAL_W-1:0]  alloc_total;
        logic [TOTAL_W-1:0]  release_total;
    } t_result;

endpackage

// ===== design/spa_front.sv =====
// front end: accepts commands, classifies them and pushes them into the queue
// depends on spa_pkg
module spa_front #(
    parameter int unsigned POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input  logic                          start,
    input  logic [spa_pkg::CMD_W-1:0]     i_command,
    input  logic [spa_pkg::IDX_W-1:0]     i_slot_index,
    input  spa_pkg::t_q_stat              i_q_stat,
    input  spa_pkg::t_back_stat           i_back_stat,
    output logic                          busy,
    output logic                          o_push,
    output spa_pkg::t_item                o_item
);
    import spa_pkg::*;

    localparam int unsigned CMP_W = IDX_W + 1;

    always_comb begin
        busy            = i_q_stat.full || i_back_stat.clearing;
        o_push          = start && !busy;
        o_item.cmd      = t_cmd'(i_command);
        o_item.idx      = i_slot_index;
        // one extra bit so a pool of 65536 slots still compares
        o_item.in_range = ({1'b0, i_slot_index} < CMP_W'(POOL_SLOTS));
    end

endmodule

// ===== design/spa_queue.sv =====
// short command queue between the front end and the execution back end
// depends on spa_pkg
module spa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spa_pkg::t_item    i_item,
    input  logic              i_pop,
    output spa_pkg::t_item    o_head,
    output spa_pkg::t_q_stat  o_stat
);
    import spa_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== design/spa_back.sv =====
// back end: free stack and occupancy memories, counters and result register
// depends on spa_pkg; takes classified commands from spa_queue
module spa_back #(
    parameter int unsigned POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spa_pkg::t_q_stat              i_q_stat,
    input  spa_pkg::t_item                i_head,
    input  logic [spa_pkg::ESIZE_W-1:0]   i_eff_size,
    output logic                          o_pop,
    output spa_pkg::t_back_stat           o_back_stat,
    output logic                          o_done,
    output spa_pkg::t_result              o_res
);
    import spa_pkg::*;

    localparam int unsigned IW     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int unsigned CW     = $clog2(POOL_SLOTS + 1);
    localparam int unsigned PROD_W = IDX_W + ESIZE_W;

    logic [IW-1:0] stack_mem [POOL_SLOTS];
    logic          occ_mem   [POOL_SLOTS];

    t_bstate         r_state, n_state;
    logic [IW-1:0]   r_clr_addr, n_clr_addr;
    logic [CW-1:0]   r_top, n_top;
    // lowest stack top seen: entries at or above it hold pushed values
    logic [CW-1:0]   r_low, n_low;
    logic [CW-1:0]   r_live, n_live;
    logic [CW-1:0]   r_peak, n_peak;
    logic [TOTAL_W-1:0] r_alloc, n_alloc;
    logic [TOTAL_W-1:0] r_release, n_release;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    t_item           r_item;
    logic            r_occ_rd;
    logic [IW-1:0]   r_stk_rd;
    logic [IW-1:0]   rd_addr;

    logic            occ_we, occ_wd;
    logic [IW-1:0]   occ_wa;
    logic            stk_we;
    logic [IW-1:0]   stk_wa, stk_wd;

    assign rd_addr = IW'(r_top - 1'b1);

    always_comb begin
        logic [IW-1:0]     slot;
        logic [IW-1:0]     idx;
        logic [PROD_W-1:0] prod;
        logic [31:0]       ext_given;
        logic [31:0]       ext_live;
        logic [31:0]       ext_peak;
        logic [IW-1:0]     given;

        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_top      = r_top;
        n_low      = r_low;
        n_live     = r_live;
        n_peak     = r_peak;
        n_alloc    = r_alloc;
        n_release  = r_release;
        n_done     = 1'b0;
        n_res      = r_res;
        o_pop      = 1'b0;
        occ_we     = 1'b0;
        occ_wa     = '0;
        occ_wd     = 1'b0;
        stk_we     = 1'b0;
        stk_wa     = '0;
        stk_wd     = '0;

        idx   = r_item.idx[IW-1:0];
        slot  = (r_top > r_low) ? r_stk_rd : IW'(r_top - 1'b1);
        prod  = PROD_W'(r_item.idx) * PROD_W'(i_eff_size);
        given = '0;
        ext_given = '0;
        ext_live  = '0;
        ext_peak  = '0;

        case (r_state)
            BK_CLEAR: begin
                occ_we = 1'b1;
                occ_wa = r_clr_addr;
                occ_wd = 1'b0;
                if (r_clr_addr == IW'(POOL_SLOTS - 1)) begin
                    n_state = BK_READ;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            BK_READ: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state           = BK_READ;
                n_done            = 1'b1;
                n_res.status      = STS_OK;
                n_res.slot_offset = '0;
                n_res.is_occupied = 1'b0;
                case (r_item.cmd)
                    CMD_ALLOC: begin
                        if (r_top == '0) begin
                            n_res.status = STS_EXHAUSTED;
                        end else begin
                            n_top = r_top - 1'b1;
                            if ((r_top - 1'b1) < r_low) begin
                                n_low = r_top - 1'b1;
                            end
                            occ_we  = 1'b1;
                            occ_wa  = slot;
                            occ_wd  = 1'b1;
                            given   = slot;
                            n_live  = r_live + 1'b1;
                            n_alloc = r_alloc + 1'b1;
                            if ((r_live + 1'b1) > r_peak) begin
                                n_peak = r_live + 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (!r_item.in_range) begin
                            n_res.status = STS_RANGE;
                        end else begin
                            given = idx;
                            case (r_item.cmd)
                                CMD_FREE: begin
                                    if (!r_occ_rd) begin
                                        n_res.status = STS_NOT_OCC;
                                    end else begin
                                        occ_we = 1'b1;
                                        occ_wa = idx;
                                        occ_wd = 1'b0;
                                        if (r_live != '0) begin
                                            n_live = r_live - 1'b1;
                                        end
                                        if (r_top < CW'(POOL_SLOTS)) begin
                                            stk_we = 1'b1;
                                            stk_wa = IW'(r_top);
                                            stk_wd = idx;
                                            n_top  = r_top + 1'b1;
                                        end
                                        n_release = r_release + 1'b1;
                                    end
                                end
                                CMD_GET: begin
                                    if (!r_occ_rd) begin
                                        n_res.status = STS_NOT_OCC;
                                    end else begin
                                        n_res.slot_offset = prod[OFFSET_W-1:0];
                                    end
                                end
                                CMD_CHECK: begin
                                    n_res.is_occupied = r_occ_rd;
                                end
                                default: begin
                                    n_res.status = STS_OK;
                                end
                            endcase
                        end
                    end
                endcase
                ext_given           = 32'(given);
                ext_live            = 32'(n_live);
                ext_peak            = 32'(n_peak);
                n_res.given_index   = ext_given[GIVEN_W-1:0];
                n_res.live_slots    = ext_live[COUNT_W-1:0];
                n_res.peak_slots    = ext_peak[COUNT_W-1:0];
                n_res.alloc_total   = n_alloc;
                n_res.release_total = n_release;
            end
            default: begin
                n_state = BK_READ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_top      <= CW'(POOL_SLOTS);
            r_low      <= CW'(POOL_SLOTS);
            r_live     <= '0;
            r_peak     <= '0;
            r_alloc    <= '0;
            r_release  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_top      <= n_top;
            r_low      <= n_low;
            r_live     <= n_live;
            r_peak     <= n_peak;
            r_alloc    <= n_alloc;
            r_release  <= n_release;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // read cycle: capture the command and both memory words
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_head;
            r_occ_rd <= occ_mem[i_head.idx[IW-1:0]];
            r_stk_rd <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[occ_wa] <= occ_wd;
        end
        if (stk_we) begin
            stack_mem[stk_wa] <= stk_wd;
        end
    end

    assign o_back_stat.clearing = (r_state == BK_CLEAR);
    assign o_done               = r_done;
    assign o_res                = r_res;

    // every slot is either on the free stack or live
    a_top_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_top) + 32'(r_live)) == 32'(POOL_SLOTS))
        else $error("stack top and live count out of balance");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top)
        else $error("low mark above stack top");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_peak)
        else $error("peak below live count");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("results closer than two cycles");

endmodule

// ===== design/slot_pool_free_list_allocator.sv =====
// top level of the slot pool allocator: configuration registers and wiring
// depends on spa_pkg, spa_front, spa_queue, spa_back
//
// After reset the block runs an occupancy clearing pass over all POOL_SLOTS
// entries with busy high; configuration writes are taken during it. A command is
// accepted when start is high and busy is low and queues in a two-entry
// buffer. The back end handles each command in BK_READ, which reads the
// free stack and occupancy memories, and then in BK_EXEC, which writes them
// back and updates the stack top, so a new command is taken from the buffer
// only after the previous one has executed; the result and o_done are
// registered from BK_EXEC. Each result is shown for exactly one cycle with o_done
// high; the receiver must take it then. Configuration may only change while
// no command is outstanding.
module slot_pool_free_list_allocator #(
    parameter int unsigned POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [spa_pkg::ESIZE_W-1:0]     i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [spa_pkg::CMD_W-1:0]       i_command,
    input  logic [spa_pkg::IDX_W-1:0]       i_slot_index,
    output logic                            o_done,
    output logic [spa_pkg::STATUS_W-1:0]    o_status,
    output logic [spa_pkg::GIVEN_W-1:0]     o_given_index,
    output logic [spa_pkg::OFFSET_W-1:0]    o_slot_offset,
    output logic                            o_is_occupied,
    output logic [spa_pkg::COUNT_W-1:0]     o_live_slots,
    output logic [spa_pkg::COUNT_W-1:0]     o_peak_slots,
    output logic [spa_pkg::TOTAL_W-1:0]     o_alloc_total,
    output logic [spa_pkg::TOTAL_W-1:0]     o_release_total
);
    import spa_pkg::*;

    logic [ESIZE_W-1:0] r_elem_size, n_elem_size;
    logic               r_cache_align, n_cache_align;
    logic [ESIZE_W-1:0] eff_size;
    logic [ESIZE_W-1:0] rounded;

    t_item       push_item;
    t_item       head;
    logic        push;
    logic        pop;
    t_q_stat     q_stat;
    t_back_stat  back_stat;
    t_result     res;

    always_comb begin
        n_elem_size   = r_elem_size;
        n_cache_align = r_cache_align;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ELEM_SIZE: begin
                    if (i_cfg_data == '0) begin
                        n_elem_size = ESIZE_W'(1);
                    end else if (i_cfg_data > ESIZE_W'(SIZE_MAX_BYTES)) begin
                        n_elem_size = ESIZE_W'(SIZE_MAX_BYTES);
                    end else begin
                        n_elem_size = i_cfg_data;
                    end
                end
                CFG_ALIGN: begin
                    n_cache_align = i_cfg_data[0];
                end
                default: begin
                    n_cache_align = r_cache_align;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_size   <= ESIZE_W'(64);
            r_cache_align <= 1'b0;
        end else begin
            r_elem_size   <= n_elem_size;
            r_cache_align <= n_cache_align;
        end
    end

    // round up to the next multiple of the alignment
    assign rounded  = (r_elem_size + ESIZE_W'(ALIGN_BYTES - 1)) & ~ESIZE_W'(ALIGN_BYTES - 1);
    assign eff_size = r_cache_align ? rounded : r_elem_size;

    spa_front #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_front (
        .start        (start),
        .i_command    (i_command),
        .i_slot_index (i_slot_index),
        .i_q_stat     (q_stat),
        .i_back_stat  (back_stat),
        .busy         (busy),
        .o_push       (push),
        .o_item       (push_item)
    );

    spa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    spa_back #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .i_eff_size  (eff_size),
        .o_pop       (pop),
        .o_back_stat (back_stat),
        .o_done      (o_done),
        .o_res       (res)
    );

    assign o_status        = res.status;
    assign o_given_index   = res.given_index;
    assign o_slot_offset   = res.slot_offset;
    assign o_is_occupied   = res.is_occupied;
    assign o_live_slots    = res.live_slots;
    assign o_peak_slots    = res.peak_slots;
    assign o_alloc_total   = res.alloc_total;
    assign o_release_total = res.release_total;

endmodule

// ===== tb/tb_slot_pool_free_list_allocator.sv =====
// testbench for slot_pool_free_list_allocator: directed and random command traffic,
// results checked against a cycle-free behavioral predictor of the free-stack pool
// depends on spa_pkg and the slot_pool_free_list_allocator RTL
module tb_slot_pool_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;

    localparam int unsigned SLOTS       = POOL_SLOTS_DEF;
    localparam int unsigned STALL_LIMIT = 5000;

    typedef struct {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
    } t_pool_cmd;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [ESIZE_W-1:0]   i_cfg_data   = '0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_command    = '0;
    logic [IDX_W-1:0]     i_slot_index = '0;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [GIVEN_W-1:0]   o_given_index;
    logic [OFFSET_W-1:0]  o_slot_offset;
    logic                 o_is_occupied;
    logic [COUNT_W-1:0]   o_live_slots;
    logic [COUNT_W-1:0]   o_peak_slots;
    logic [TOTAL_W-1:0]   o_alloc_total;
    logic [TOTAL_W-1:0]   o_release_total;

    t_pool_cmd cmd_backlog[$];
    t_pool_cmd next_cmd;
    t_result   expected_responses[$];
    t_result   want;
    bit        cmd_taken    = 1'b0;
    int        gap_left     = 0;
    int        gap_pct      = 0;
    int        stall_cycles = 0;
    int        mismatches   = 0;

    // predictor state
    logic [GIVEN_W-1:0] free_slots [SLOTS];
    bit                 slot_busy  [SLOTS];
    int unsigned        stack_depth;
    int unsigned        live_cnt;
    int unsigned        peak_cnt;
    logic [TOTAL_W-1:0] alloc_tot;
    logic [TOTAL_W-1:0] release_tot;
    int unsigned        elem_bytes;
    bit                 align_on;

    slot_pool_free_list_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_slot_index   (i_slot_index),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_given_index  (o_given_index),
        .o_slot_offset  (o_slot_offset),
        .o_is_occupied  (o_is_occupied),
        .o_live_slots   (o_live_slots),
        .o_peak_slots   (o_peak_slots),
        .o_alloc_total  (o_alloc_total),
        .o_release_total(o_release_total)
    );

    always #1 i_clk = ~i_clk;

    task automatic predict_pool_response(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                         output t_result r);
        logic [GIVEN_W-1:0] slot;
        int unsigned        unit;
        logic [31:0]        prod;
        r = '0;
        r.status = STS_OK;
        if (cmd == CMD_ALLOC) begin
            if (stack_depth == 0) begin
                r.status = STS_EXHAUSTED;
            end else begin
                stack_depth--;
                slot = free_slots[stack_depth];
                slot_busy[slot] = 1'b1;
                r.given_index = slot;
                live_cnt++;
                alloc_tot++;
                if (live_cnt > peak_cnt) peak_cnt = live_cnt;
            end
        end else if (idx >= SLOTS) begin
            r.status = STS_RANGE;
        end else begin
            r.given_index = idx[GIVEN_W-1:0];
            case (cmd)
                CMD_FREE: begin
                    if (!slot_busy[idx]) begin
                        r.status = STS_NOT_OCC;
                    end else begin
                        slot_busy[idx] = 1'b0;
                        if (live_cnt > 0) live_cnt--;
                        if (stack_depth < SLOTS) begin
                            free_slots[stack_depth] = idx[GIVEN_W-1:0];
                            stack_depth++;
                        end
                        release_tot++;
                    end
                end
                CMD_GET: begin
                    if (!slot_busy[idx]) begin
                        r.status = STS_NOT_OCC;
                    end else begin
                        unit = elem_bytes;
                        if (align_on) unit = (unit + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
                        prod = idx * unit;
                        r.slot_offset = prod[OFFSET_W-1:0];
                    end
                end
                default: r.is_occupied = slot_busy[idx];
            endcase
        end
        r.live_slots    = live_cnt[COUNT_W-1:0];
        r.peak_slots    = peak_cnt[COUNT_W-1:0];
        r.alloc_total   = alloc_tot;
        r.release_total = release_tot;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // driver: presents the next backlog entry, with random idle bursts between transactions
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_taken && $urandom_range(0, 99) < gap_pct)
                gap_left = $urandom_range(1, 13);
            if (gap_left == 0 && cmd_backlog.size() != 0) begin
                next_cmd = cmd_backlog.pop_front();
                start        <= 1'b1;
                i_command    <= next_cmd.cmd;
                i_slot_index <= next_cmd.idx;
            end else begin
                if (gap_left > 0) gap_left--;
                start        <= 1'b0;
                i_command    <= CMD_W'($urandom_range(0, 3));
                i_slot_index <= IDX_W'($urandom_range(0, 65535));
            end
        end
    end

    // monitor: predicts on each accepted command and checks each result
    always @(posedge i_clk) begin
        cmd_taken = (i_rst_n === 1'b1) && (start === 1'b1) && (busy === 1'b0);
        if (cmd_taken) begin
            predict_pool_response(t_cmd'(i_command), i_slot_index, want);
            expected_responses.push_back(want);
        end
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: result with no command outstanding, expected none, actual status %0d",
                         $time, o_status);
                mismatches++;
            end else begin
                want = expected_responses.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("given_index", 32'(want.given_index), 32'(o_given_index));
                check_field("slot_offset", 32'(want.slot_offset), 32'(o_slot_offset));
                check_field("is_occupied", 32'(want.is_occupied), 32'(o_is_occupied));
                check_field("live_slots", 32'(want.live_slots), 32'(o_live_slots));
                check_field("peak_slots", 32'(want.peak_slots), 32'(o_peak_slots));
                check_field("alloc_total", want.alloc_total, o_alloc_total);
                check_field("release_total", want.release_total, o_release_total);
            end
        end
        if (cmd_taken || (i_rst_n === 1'b1 && o_done === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic queue_cmd(input t_cmd cmd, input logic [IDX_W-1:0] idx);
        t_pool_cmd item;
        while (cmd_backlog.size() >= 2) @(posedge i_clk);
        item.cmd = cmd;
        item.idx = idx;
        cmd_backlog.push_back(item);
    endtask

    // mostly live slots so frees and gets succeed, some free or out-of-range indexes
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            base = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
                if (slot_busy[(base + k) % SLOTS]) return IDX_W'((base + k) % SLOTS);
            return IDX_W'(base);
        end
        if (pick < 85) return IDX_W'($urandom_range(0, SLOTS - 1));
        if (pick < 93) return IDX_W'($urandom_range(SLOTS, 65535));
        return IDX_W'($urandom_range(0, 65535));
    endfunction

    task automatic run_mix(input int n, input int w_alloc, input int w_free, input int w_get);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < w_alloc)
                queue_cmd(CMD_ALLOC, IDX_W'($urandom_range(0, 65535)));
            else if (pick < w_alloc + w_free)
                queue_cmd(CMD_FREE, pick_index());
            else if (pick < w_alloc + w_free + w_get)
                queue_cmd(CMD_GET, pick_index());
            else
                queue_cmd(CMD_CHECK, pick_index());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ESIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_ELEM_SIZE) begin
            elem_bytes = 32'(val);
            if (elem_bytes == 0) elem_bytes = 1;
            if (elem_bytes > SIZE_MAX_BYTES) elem_bytes = SIZE_MAX_BYTES;
        end else begin
            align_on = val[0];
        end
    endtask

    // wait until every command is accepted and answered
    task automatic settle();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || expected_responses.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int allocs;
        for (int i = 0; i < SLOTS; i++) begin
            free_slots[i] = GIVEN_W'(i);
            slot_busy[i]  = 1'b0;
        end
        stack_depth = SLOTS;
        live_cnt    = 0;
        peak_cnt    = 0;
        alloc_tot   = '0;
        release_tot = '0;
        elem_bytes  = 64;
        align_on    = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // oversized write clamps to the largest element size
        write_reg(CFG_ELEM_SIZE, 13'h1FFF);
        write_reg(CFG_ALIGN, 13'h0000);
        gap_pct = 25;
        queue_cmd(CMD_CHECK, 16'd0);
        queue_cmd(CMD_GET, 16'd0);
        queue_cmd(CMD_FREE, 16'd0);
        queue_cmd(CMD_FREE, IDX_W'(SLOTS));
        queue_cmd(CMD_GET, 16'hFFFF);
        queue_cmd(CMD_CHECK, IDX_W'(SLOTS));
        queue_cmd(CMD_CHECK, 16'hFFFF);
        queue_cmd(CMD_ALLOC, 16'd0);
        queue_cmd(CMD_ALLOC, 16'hFFFF);
        queue_cmd(CMD_GET, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_CHECK, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_FREE, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_FREE, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_GET, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_ALLOC, 16'h5555);
        queue_cmd(CMD_FREE, IDX_W'(SLOTS - 2));
        queue_cmd(CMD_FREE, IDX_W'(SLOTS - 1));
        queue_cmd(CMD_ALLOC, 16'hAAAA);
        queue_cmd(CMD_ALLOC, 16'd0);
        queue_cmd(CMD_GET, IDX_W'(SLOTS - 2));
        queue_cmd(CMD_CHECK, IDX_W'(SLOTS - 2));
        queue_cmd(CMD_CHECK, 16'd1);
        settle();

        // zero size clamps to one byte; align takes bit 0 only
        write_reg(CFG_ELEM_SIZE, 13'h0000);
        write_reg(CFG_ALIGN, 13'h1FFE);
        gap_pct = 35;
        run_mix(250, 30, 25, 25);
        settle();

        // fill the pool until allocs run into exhaustion
        write_reg(CFG_ELEM_SIZE, 13'd100);
        write_reg(CFG_ALIGN, 13'd1);
        gap_pct = 15;
        allocs = 0;
        while (allocs < SLOTS + 16) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 1)
                    queue_cmd(CMD_GET, pick_index());
                else
                    queue_cmd(CMD_CHECK, pick_index());
            end else begin
                queue_cmd(CMD_ALLOC, IDX_W'($urandom_range(0, 65535)));
                allocs++;
            end
        end
        settle();

        // churn near a full pool
        write_reg(CFG_ELEM_SIZE, 13'd4097);
        write_reg(CFG_ALIGN, 13'd1);
        gap_pct = 30;
        run_mix(120, 35, 35, 15);
        settle();

        // back-to-back traffic to close the run
        write_reg(CFG_ELEM_SIZE, 13'd1);
        write_reg(CFG_ALIGN, 13'd3);
        gap_pct = 0;
        run_mix(110, 35, 35, 15);
        settle();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
